@@ rtl/core/tef_pkg.sv @@
`default_nettype none

package tef_pkg;

	typedef struct packed {
		logic [15:0] raw_x;
		logic [15:0] raw_y;
		logic        touched;
	} in_item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [8:0] point_x;
		logic [8:0] point_y;
	} out_item_t;

	localparam logic [1:0] KIND_DOWN = 2'd0;
	localparam logic [1:0] KIND_DRAG = 2'd1;
	localparam logic [1:0] KIND_UP   = 2'd2;

	// register index, paddr[4:2]
	localparam logic [2:0] REG_OFFSET_X    = 3'd0;
	localparam logic [2:0] REG_SCALE_X     = 3'd1;
	localparam logic [2:0] REG_OFFSET_Y    = 3'd2;
	localparam logic [2:0] REG_SCALE_Y     = 3'd3;
	localparam logic [2:0] REG_TOLERANCE_X = 3'd4;
	localparam logic [2:0] REG_TOLERANCE_Y = 3'd5;

	localparam logic [15:0] RST_OFFSET_X    = 16'd5120;
	localparam logic [9:0]  RST_SCALE_X     = 10'd115;
	localparam logic [15:0] RST_OFFSET_Y    = 16'd12288;
	localparam logic [9:0]  RST_SCALE_Y     = 10'd147;
	localparam logic [15:0] RST_TOLERANCE_X = 16'd256;
	localparam logic [15:0] RST_TOLERANCE_Y = 16'd256;

endpackage

`default_nettype wire

@@ rtl/core/touch_event_filter.sv @@
// touch_event_filter: raw touch samples in, pen events out
//
// input channel (in_valid/in_stall/in_data) carries one raw sample per
// transaction; output channel (out_valid/out_stall/out_data) carries one pen
// event per transaction: pen down on a new touch, pen drag when an axis moves
// past its tolerance, pen up with the last point on release. samples that
// cause no event are consumed silently.
// each moved axis goes through one shared restoring divider, one quotient bit
// per cycle: a setup state (S_LOAD) plus 16 divide steps (S_DIV) per axis. a
// sample with moved axes passes S_LOAD and S_DIV for each of them, then S_EMIT,
// where out_valid is loaded; a release goes straight to S_EMIT. in_stall stays
// high until the event is loaded into the output register, so no new sample is taken before it.
// the output register holds while out_stall is high; the next sample is taken
// meanwhile and its event waits in the final state for the register to free.
// reset (arst_n low) loads the default calibration, clears the touch state and
// the last point to zero and drops out_valid. calibration must be written over the
// apb port only while the block is idle; the block itself does not enforce this.
`default_nettype none

module touch_event_filter #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 272
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire tef_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output tef_pkg::out_item_t     out_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam logic [15:0] LIMIT_X = 16'(SCREEN_WIDTH - 1);
	localparam logic [15:0] LIMIT_Y = 16'(SCREEN_HEIGHT - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_DIV  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q;

	logic [15:0] offset_x_q, offset_y_q, tolerance_x_q, tolerance_y_q;
	logic [9:0]  scale_x_q, scale_y_q;

	logic        was_touched_q;
	logic [15:0] last_raw_x_q, last_raw_y_q;
	logic [8:0]  last_point_x_q, last_point_y_q;

	logic        axis_q;      // 0: x, 1: y
	logic        move_y_q;
	logic [1:0]  kind_q;
	logic [15:0] quo_q;
	logic [9:0]  rem_q;
	logic [3:0]  count_q;

	logic        out_valid_q;
	tef_pkg::out_item_t out_data_q;

	logic        in_fire, cfg_write, fresh, move_x, move_y;
	logic [15:0] diff_x, diff_y;
	logic [15:0] op_raw, op_off, op_value;
	logic [9:0]  div_scale;
	logic [10:0] trial;
	logic        trial_ge;
	logic [15:0] quo_next, clamp_x, clamp_y, inv_y;
	logic        out_free;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		unique case (paddr[4:2])
			tef_pkg::REG_OFFSET_X:    prdata = {16'd0, offset_x_q};
			tef_pkg::REG_SCALE_X:     prdata = {22'd0, scale_x_q};
			tef_pkg::REG_OFFSET_Y:    prdata = {16'd0, offset_y_q};
			tef_pkg::REG_SCALE_Y:     prdata = {22'd0, scale_y_q};
			tef_pkg::REG_TOLERANCE_X: prdata = {16'd0, tolerance_x_q};
			tef_pkg::REG_TOLERANCE_Y: prdata = {16'd0, tolerance_y_q};
			default:                  prdata = 32'd0;
		endcase
	end

	always_comb begin
		diff_x = (in_data.raw_x >= last_raw_x_q) ? in_data.raw_x - last_raw_x_q
		                                        : last_raw_x_q - in_data.raw_x;
		diff_y = (in_data.raw_y >= last_raw_y_q) ? in_data.raw_y - last_raw_y_q
		                                        : last_raw_y_q - in_data.raw_y;
		fresh  = !was_touched_q;
		move_x = fresh || (diff_x > tolerance_x_q);
		move_y = fresh || (diff_y > tolerance_y_q);
	end

	// operand setup and divide step share the axis select
	always_comb begin
		op_raw    = axis_q ? last_raw_y_q : last_raw_x_q;
		op_off    = axis_q ? offset_y_q : offset_x_q;
		op_value  = (op_raw >= op_off) ? op_raw - op_off : 16'd0;
		div_scale = axis_q ? scale_y_q : scale_x_q;
		trial     = {rem_q, quo_q[15]};
		// a zero scale sets every quotient bit, which clamps to the limit
		trial_ge  = trial >= {1'b0, div_scale};
		quo_next  = {quo_q[14:0], trial_ge};
		clamp_x   = (quo_next > LIMIT_X) ? LIMIT_X : quo_next;
		clamp_y   = (quo_next > LIMIT_Y) ? LIMIT_Y : quo_next;
		inv_y     = LIMIT_Y - clamp_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q    <= tef_pkg::RST_OFFSET_X;
			scale_x_q     <= tef_pkg::RST_SCALE_X;
			offset_y_q    <= tef_pkg::RST_OFFSET_Y;
			scale_y_q     <= tef_pkg::RST_SCALE_Y;
			tolerance_x_q <= tef_pkg::RST_TOLERANCE_X;
			tolerance_y_q <= tef_pkg::RST_TOLERANCE_Y;
		end else if (cfg_write) begin
			unique case (paddr[4:2])
				tef_pkg::REG_OFFSET_X:    offset_x_q    <= pwdata[15:0];
				tef_pkg::REG_SCALE_X:     scale_x_q     <= pwdata[9:0];
				tef_pkg::REG_OFFSET_Y:    offset_y_q    <= pwdata[15:0];
				tef_pkg::REG_SCALE_Y:     scale_y_q     <= pwdata[9:0];
				tef_pkg::REG_TOLERANCE_X: tolerance_x_q <= pwdata[15:0];
				tef_pkg::REG_TOLERANCE_Y: tolerance_y_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			was_touched_q  <= 1'b0;
			last_raw_x_q   <= 16'd0;
			last_raw_y_q   <= 16'd0;
			last_point_x_q <= 9'd0;
			last_point_y_q <= 9'd0;
			axis_q         <= 1'b0;
			move_y_q       <= 1'b0;
			kind_q         <= tef_pkg::KIND_DOWN;
			count_q        <= 4'd0;
			out_valid_q    <= 1'b0;
		end else begin
			// load on emit, otherwise drop once the receiver takes the transaction
			if (state_q == S_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						was_touched_q <= in_data.touched;
						if (in_data.touched && (move_x || move_y)) begin
							if (move_x)
								last_raw_x_q <= in_data.raw_x;
							if (move_y)
								last_raw_y_q <= in_data.raw_y;
							axis_q   <= !move_x;
							move_y_q <= move_y;
							kind_q   <= fresh ? tef_pkg::KIND_DOWN : tef_pkg::KIND_DRAG;
							state_q  <= S_LOAD;
						end else if (!in_data.touched && was_touched_q) begin
							kind_q  <= tef_pkg::KIND_UP;
							state_q <= S_EMIT;
						end
					end
				end
				S_LOAD: begin
					count_q <= 4'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					count_q <= count_q + 4'd1;
					if (&count_q) begin
						if (!axis_q) begin
							last_point_x_q <= clamp_x[8:0];
							if (move_y_q) begin
								axis_q  <= 1'b1;
								state_q <= S_LOAD;
							end else begin
								state_q <= S_EMIT;
							end
						end else begin
							last_point_y_q <= inv_y[8:0];
							state_q        <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// divider datapath and output payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			quo_q <= op_value;
			rem_q <= 10'd0;
		end else if (state_q == S_DIV) begin
			quo_q <= quo_next;
			rem_q <= trial_ge ? 10'(trial - {1'b0, div_scale}) : trial[9:0];
		end
		if (state_q == S_EMIT && out_free) begin
			out_data_q.event_kind <= kind_q;
			out_data_q.point_x    <= last_point_x_q;
			out_data_q.point_y    <= last_point_y_q;
		end
	end

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("output valid raised outside the emit state");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (&count_q) |=> (state_q == S_LOAD) || (state_q == S_EMIT))
		else $error("divider did not hand off after its last step");

	a_silent_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !in_data.touched && !was_touched_q |=> state_q == S_IDLE)
		else $error("idle sample without touch produced work");

	a_second_axis_y: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (&count_q) && !axis_q && move_y_q |=> axis_q)
		else $error("second divide pass did not switch to the y axis");

endmodule

`default_nettype wire

@@ sim/tef_event_checker.sv @@
`timescale 1ns / 100ps

module tef_event_checker #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 272
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire tef_pkg::in_item_t in_data,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire tef_pkg::out_item_t out_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output int                     errors,
	output int                     pending,
	output int                     downs,
	output int                     drags,
	output int                     ups
);

	logic [15:0] cal_offset_x, cal_offset_y, cal_tol_x, cal_tol_y;
	logic [9:0]  cal_scale_x, cal_scale_y;
	logic        pen_held;
	logic [15:0] held_raw_x, held_raw_y;
	logic [8:0]  held_px, held_py;
	tef_pkg::out_item_t pen_events[$];

	function automatic int unsigned to_screen(input logic [15:0] raw, input logic [15:0] base,
			input logic [9:0] divisor, input int unsigned top_px);
		int unsigned span;
		span = (raw >= base) ? 32'(raw - base) : 32'd0;
		if (divisor == 10'd0)
			return top_px;
		span = span / 32'(divisor);
		return (span > top_px) ? top_px : span;
	endfunction

	function automatic logic [15:0] distance(input logic [15:0] a, input logic [15:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		tef_pkg::in_item_t  smp;
		tef_pkg::out_item_t got, want, ev;
		logic         fresh, move_x, move_y;
		int unsigned  px, py;
		if (!arst_n) begin
			cal_offset_x = tef_pkg::RST_OFFSET_X;
			cal_scale_x  = tef_pkg::RST_SCALE_X;
			cal_offset_y = tef_pkg::RST_OFFSET_Y;
			cal_scale_y  = tef_pkg::RST_SCALE_Y;
			cal_tol_x    = tef_pkg::RST_TOLERANCE_X;
			cal_tol_y    = tef_pkg::RST_TOLERANCE_Y;
			pen_held     = 1'b0;
			held_raw_x   = '0;
			held_raw_y   = '0;
			held_px      = '0;
			held_py      = '0;
			pen_events.delete();
			errors = 0;
			downs  = 0;
			drags  = 0;
			ups    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					tef_pkg::REG_OFFSET_X:    cal_offset_x = pwdata[15:0];
					tef_pkg::REG_SCALE_X:     cal_scale_x  = pwdata[9:0];
					tef_pkg::REG_OFFSET_Y:    cal_offset_y = pwdata[15:0];
					tef_pkg::REG_SCALE_Y:     cal_scale_y  = pwdata[9:0];
					tef_pkg::REG_TOLERANCE_X: cal_tol_x    = pwdata[15:0];
					tef_pkg::REG_TOLERANCE_Y: cal_tol_y    = pwdata[15:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				got = out_data;
				if (pen_events.size() == 0) begin
					errors++;
					$display("%t unexpected pen event: kind %0d x %0d y %0d", $time,
						got.event_kind, got.point_x, got.point_y);
				end else begin
					want = pen_events.pop_front();
					if (got.event_kind !== want.event_kind || got.point_x !== want.point_x ||
							got.point_y !== want.point_y) begin
						errors++;
						$display("%t pen event mismatch: expected kind %0d x %0d y %0d",
							$time, want.event_kind, want.point_x, want.point_y,
							", got kind %0d x %0d y %0d",
							got.event_kind, got.point_x, got.point_y);
					end
				end
			end

			if (in_valid && !in_stall) begin
				smp = in_data;
				if (smp.touched) begin
					fresh  = !pen_held;
					move_x = fresh || distance(smp.raw_x, held_raw_x) > cal_tol_x;
					move_y = fresh || distance(smp.raw_y, held_raw_y) > cal_tol_y;
					if (move_x) begin
						held_raw_x = smp.raw_x;
						px = to_screen(smp.raw_x, cal_offset_x, cal_scale_x,
							32'(SCREEN_WIDTH - 1));
						held_px = px[8:0];
					end
					if (move_y) begin
						held_raw_y = smp.raw_y;
						// screen y runs the other way
						py = 32'(SCREEN_HEIGHT - 1) - to_screen(smp.raw_y, cal_offset_y,
							cal_scale_y, 32'(SCREEN_HEIGHT - 1));
						held_py = py[8:0];
					end
					if (move_x || move_y) begin
						ev.event_kind = fresh ? tef_pkg::KIND_DOWN : tef_pkg::KIND_DRAG;
						ev.point_x    = held_px;
						ev.point_y    = held_py;
						pen_events.push_back(ev);
						if (fresh)
							downs++;
						else
							drags++;
					end
				end else if (pen_held) begin
					ev.event_kind = tef_pkg::KIND_UP;
					ev.point_x    = held_px;
					ev.point_y    = held_py;
					pen_events.push_back(ev);
					ups++;
				end
				pen_held = smp.touched;
			end
		end
		pending = pen_events.size();
	end

endmodule

@@ sim/tb_touch_event_filter.sv @@
`timescale 1ns / 100ps

module tb_touch_event_filter;

	localparam int WATCHDOG_LIMIT      = 5000;
	localparam int HOLD_OFF_CYCLES     = 400;
	localparam int SETTLE_CYCLES       = 48;
	localparam int SAMPLES_PER_SETTING = 205;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	tef_pkg::in_item_t  in_data;
	logic        out_valid;
	logic        out_stall;
	tef_pkg::out_item_t out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int errors, pending, downs, drags, ups;
	int tx_idle_pct, rx_idle_pct;
	int counted;
	int idle_cycles = 0;
	bit hold_req;
	bit touching;
	logic [15:0] tol_x, tol_y;

	touch_event_filter dut (.*);

	tef_event_checker event_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver side: random stall, plus one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic tef_pkg::in_item_t sample(input logic [15:0] x, input logic [15:0] y,
			input logic t);
		tef_pkg::in_item_t s;
		s.raw_x   = x;
		s.raw_y   = y;
		s.touched = t;
		return s;
	endfunction

	function automatic logic [15:0] rand16();
		return 16'($urandom_range(65535));
	endfunction

	// step away from a position by none, exactly the tolerance, just past it, anything within it, or anything
	function automatic logic [15:0] nudge(input logic [15:0] base, input logic [15:0] tol);
		int unsigned step;
		int          v;
		case ($urandom_range(4))
			0: step = 0;
			1: step = 32'(tol);
			2: step = 32'(tol) + 1;
			3: step = $urandom_range(32'(tol));
			default: step = $urandom_range(65535);
		endcase
		v = $urandom_range(1) ? int'(base) + int'(step) : int'(base) - int'(step);
		if (v < 0)
			v = 0;
		else if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	task automatic send_sample(input tef_pkg::in_item_t s);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (s.touched || touching)
			counted++;
		touching = s.touched;
	endtask

	// wait until every pen event is in, then give a silent sample time to finish
	task automatic drain;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic calibrate(input logic [15:0] ox, input logic [9:0] sx, input logic [15:0] oy,
			input logic [9:0] sy, input logic [15:0] tx, input logic [15:0] ty);
		drain();
		apb_write(tef_pkg::REG_OFFSET_X, ox);
		apb_write(tef_pkg::REG_SCALE_X, {6'd0, sx});
		apb_write(tef_pkg::REG_OFFSET_Y, oy);
		apb_write(tef_pkg::REG_SCALE_Y, {6'd0, sy});
		apb_write(tef_pkg::REG_TOLERANCE_X, tx);
		apb_write(tef_pkg::REG_TOLERANCE_Y, ty);
		tol_x = tx;
		tol_y = ty;
	endtask

	// touch down, a few moves, usually a release
	task automatic gesture;
		logic [15:0] x, y;
		int          moves;
		x = rand16();
		y = rand16();
		send_sample(sample(x, y, 1'b1));
		moves = int'($urandom_range(8));
		repeat (moves) begin
			x = nudge(x, tol_x);
			y = nudge(y, tol_y);
			send_sample(sample(x, y, 1'b1));
		end
		if ($urandom_range(99) < 85)
			send_sample(sample(rand16(), rand16(), 1'b0));
	endtask

	initial begin
		bit held_once;
		bit paused;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		hold_req    = 1'b0;
		touching    = 1'b0;
		tx_idle_pct = 36;
		rx_idle_pct = 88;
		tol_x       = tef_pkg::RST_TOLERANCE_X;
		tol_y       = tef_pkg::RST_TOLERANCE_Y;
		held_once   = 1'b0;
		paused      = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, default calibration
		send_sample(sample(16'h1234, 16'h5678, 1'b0));
		send_sample(sample(16'h0000, 16'hFFFF, 1'b1));  // lands on the origin
		send_sample(sample(16'hAAAA, 16'h5555, 1'b0));
		send_sample(sample(16'hFFFF, 16'h0000, 1'b1));
		send_sample(sample(16'hFEFF, 16'h0100, 1'b1));  // both exactly at tolerance
		send_sample(sample(16'hFEFE, 16'h0100, 1'b1));  // x only
		send_sample(sample(16'hFEFE, 16'h0101, 1'b1));  // y only
		send_sample(sample(16'd30000, 16'd30000, 1'b1));
		send_sample(sample(16'd5120, 16'd12288, 1'b1));
		send_sample(sample(16'd60205, 16'd52125, 1'b1));
		send_sample(sample(16'd60204, 16'd52124, 1'b1));
		send_sample(sample(16'h5555, 16'hAAAA, 1'b0));
		send_sample(sample(16'hFFFF, 16'hFFFF, 1'b0));
		send_sample(sample(16'h0000, 16'h0000, 1'b1));
		send_sample(sample(16'h0000, 16'h0000, 1'b1));
		send_sample(sample(16'h0000, 16'h0000, 1'b0));

		for (int setting = 0; setting < 6; setting++) begin
			case (setting / 2)
				0: begin
					tx_idle_pct = 36;
					rx_idle_pct = 88;
				end
				1: begin
					tx_idle_pct = 88;
					rx_idle_pct = 36;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			case (setting)
				1: calibrate(16'd0, 10'd1, 16'd0, 10'd1, 16'd0, 16'd0);
				2: calibrate(16'hFFFF, 10'd1023, 16'hFFFF, 10'd1023, 16'hFFFF, 16'hFFFF);
				3: calibrate(16'($urandom_range(8000)), 10'd0, 16'($urandom_range(8000)), 10'd0,
					16'($urandom_range(2000)), 16'($urandom_range(2000)));
				4: calibrate(16'($urandom_range(20000)), 10'($urandom_range(1023, 1)),
					16'($urandom_range(20000)), 10'($urandom_range(1023, 1)),
					16'($urandom_range(3000)), 16'($urandom_range(3000)));
				5: calibrate(16'd1000, 10'd0, 16'd2000, 10'd230, 16'd100, 16'd300);
				default: ;
			endcase
			counted = 0;
			while (counted < SAMPLES_PER_SETTING) begin
				if (setting == 4 && !held_once && counted >= 60) begin
					hold_req  = 1'b1;
					held_once = 1'b1;
				end
				if (setting == 1 && !paused && counted >= 100) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(99) < 80)
					gesture();
				else
					send_sample(sample(rand16(), rand16(), 1'($urandom_range(1))));
			end
		end

		drain();
		$display("checked %0d pen down, %0d drag and %0d pen up events", downs, drags, ups);
		$display("over six calibrations incl. zero and full-range scales, offsets, tolerances");
		if (pending != 0)
			$display("%t %0d pen events never arrived", $time, pending);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
